// ----- rtl/hsce_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hsce_pkg: shared types, constants and functions for the character escaper
// Holds character codes, the byte class encoding and escape sequence tables.
// ----------------------------------------------------------------------------
package hsce_pkg;

    localparam int BYTE_W      = 8;
    localparam int MAX_RUN     = 6;
    localparam int IDX_W       = 3;
    localparam int QUEUE_DEPTH = 2;

    typedef logic [BYTE_W-1:0] byte_t;
    typedef logic [IDX_W-1:0]  idx_t;

    localparam byte_t CH_LT     = 8'h3C;
    localparam byte_t CH_GT     = 8'h3E;
    localparam byte_t CH_AMP    = 8'h26;
    localparam byte_t CH_QUOT   = 8'h22;
    localparam byte_t CH_APOS   = 8'h27;
    localparam byte_t CH_SEMI   = 8'h3B;
    localparam byte_t CH_DASH   = 8'h2D;
    localparam byte_t CH_SLASH  = 8'h2F;
    localparam byte_t CH_BSLASH = 8'h5C;
    localparam byte_t CH_PCT    = 8'h25;
    localparam byte_t CH_USCORE = 8'h5F;
    localparam byte_t CH_HASH   = 8'h23;
    localparam byte_t CH_3      = 8'h33;
    localparam byte_t CH_9      = 8'h39;
    localparam byte_t CH_A      = 8'h61;
    localparam byte_t CH_G      = 8'h67;
    localparam byte_t CH_L      = 8'h6C;
    localparam byte_t CH_M      = 8'h6D;
    localparam byte_t CH_O      = 8'h6F;
    localparam byte_t CH_P      = 8'h70;
    localparam byte_t CH_Q      = 8'h71;
    localparam byte_t CH_T      = 8'h74;
    localparam byte_t CH_U      = 8'h75;
    localparam byte_t PRINT_LO  = 8'h20;
    localparam byte_t PRINT_HI  = 8'h7E;

    typedef enum logic [2:0] {
        CLS_DROP,
        CLS_PASS,
        CLS_BSLASH,
        CLS_LT,
        CLS_GT,
        CLS_AMP,
        CLS_QUOT,
        CLS_APOS
    } hsce_class_t;

    typedef struct packed {
        hsce_class_t cls;
        byte_t       ch;
    } hsce_entry_t;

    function automatic hsce_class_t classify(input byte_t ch);
        hsce_class_t cls;
        unique case (ch)
            CH_LT:     cls = CLS_LT;
            CH_GT:     cls = CLS_GT;
            CH_AMP:    cls = CLS_AMP;
            CH_QUOT:   cls = CLS_QUOT;
            CH_APOS:   cls = CLS_APOS;
            CH_SEMI,
            CH_DASH,
            CH_SLASH,
            CH_BSLASH,
            CH_PCT,
            CH_USCORE: cls = CLS_BSLASH;
            default:   cls = (ch >= PRINT_LO && ch <= PRINT_HI) ? CLS_PASS : CLS_DROP;
        endcase
        return cls;
    endfunction

    // number of bytes emitted for a class
    function automatic idx_t run_len(input hsce_class_t cls);
        idx_t len;
        unique case (cls)
            CLS_PASS:   len = IDX_W'(1);
            CLS_BSLASH: len = IDX_W'(2);
            CLS_LT:     len = IDX_W'(4);
            CLS_GT:     len = IDX_W'(4);
            CLS_AMP:    len = IDX_W'(5);
            CLS_QUOT:   len = IDX_W'(6);
            CLS_APOS:   len = IDX_W'(5);
            default:    len = IDX_W'(0);
        endcase
        return len;
    endfunction

    // byte at position idx of the escape sequence
    function automatic byte_t run_byte(input hsce_class_t cls, input byte_t ch,
                                       input idx_t idx);
        byte_t b;
        b = ch;
        unique case (cls)
            CLS_BSLASH: b = (idx == IDX_W'(0)) ? CH_BSLASH : ch;
            CLS_LT:
                unique case (idx)
                    IDX_W'(0): b = CH_AMP;
                    IDX_W'(1): b = CH_L;
                    IDX_W'(2): b = CH_T;
                    default:   b = CH_SEMI;
                endcase
            CLS_GT:
                unique case (idx)
                    IDX_W'(0): b = CH_AMP;
                    IDX_W'(1): b = CH_G;
                    IDX_W'(2): b = CH_T;
                    default:   b = CH_SEMI;
                endcase
            CLS_AMP:
                unique case (idx)
                    IDX_W'(0): b = CH_AMP;
                    IDX_W'(1): b = CH_A;
                    IDX_W'(2): b = CH_M;
                    IDX_W'(3): b = CH_P;
                    default:   b = CH_SEMI;
                endcase
            CLS_QUOT:
                unique case (idx)
                    IDX_W'(0): b = CH_AMP;
                    IDX_W'(1): b = CH_Q;
                    IDX_W'(2): b = CH_U;
                    IDX_W'(3): b = CH_O;
                    IDX_W'(4): b = CH_T;
                    default:   b = CH_SEMI;
                endcase
            CLS_APOS:
                unique case (idx)
                    IDX_W'(0): b = CH_AMP;
                    IDX_W'(1): b = CH_HASH;
                    IDX_W'(2): b = CH_3;
                    IDX_W'(3): b = CH_9;
                    default:   b = CH_SEMI;
                endcase
            default:    b = ch;
        endcase
        return b;
    endfunction

endpackage

// ----- rtl/hsce_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hsce_if: valid/ready channels of the character escaper
// Raw text byte channel and escaped byte channel.
// ----------------------------------------------------------------------------
interface hsce_in_if;
    logic                  valid;
    logic                  ready;
    logic [hsce_pkg::BYTE_W-1:0] in_byte;

    modport source (output valid, output in_byte, input ready);
    modport sink   (input valid, input in_byte, output ready);
endinterface

interface hsce_out_if;
    logic                  valid;
    logic                  ready;
    logic [hsce_pkg::BYTE_W-1:0] out_byte;
    logic                  run_last;

    modport source (output valid, output out_byte, output run_last, input ready);
    modport sink   (input valid, input out_byte, input run_last, output ready);
endinterface

// ----- rtl/hsce_front.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hsce_front: request intake and classification
// Registers each accepted byte with its class; dropped bytes go no further.
// ----------------------------------------------------------------------------
module hsce_front (
    input  logic                 clk,
    input  logic                 rst_n,
    hsce_in_if.sink              raw,
    output logic                 push_valid,
    output hsce_pkg::hsce_entry_t push_entry,
    input  logic                 push_ready
);

    logic                  stage_valid_reg;
    logic                  stage_valid_next;
    hsce_pkg::hsce_entry_t stage_entry_reg;
    hsce_pkg::hsce_class_t cls;
    logic                  accept;

    assign cls       = hsce_pkg::classify(raw.in_byte);
    assign raw.ready = !stage_valid_reg || push_ready;
    assign accept    = raw.valid && raw.ready;

    always_comb
    begin
        if (accept)
            stage_valid_next = (cls != hsce_pkg::CLS_DROP);
        else if (push_ready)
            stage_valid_next = 1'b0;
        else
            stage_valid_next = stage_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            stage_valid_reg <= 1'b0;
        else
            stage_valid_reg <= stage_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            stage_entry_reg.cls <= cls;
            stage_entry_reg.ch  <= raw.in_byte;
        end
    end

    assign push_valid = stage_valid_reg;
    assign push_entry = stage_entry_reg;

endmodule

// ----- rtl/hsce_queue.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hsce_queue: classified request queue
// Small FIFO that decouples classification from sequence emission.
// ----------------------------------------------------------------------------
module hsce_queue #(
    parameter int DEPTH = hsce_pkg::QUEUE_DEPTH
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  push_valid,
    input  hsce_pkg::hsce_entry_t push_entry,
    output logic                  push_ready,
    output logic                  pop_valid,
    output hsce_pkg::hsce_entry_t pop_entry,
    input  logic                  pop
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    hsce_pkg::hsce_entry_t mem [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_push;
    logic             do_pop;

    assign push_ready = (count_reg != CNT_W'(DEPTH));
    assign pop_valid  = (count_reg != CNT_W'(0));
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop && pop_valid;
    assign pop_entry  = mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
        if (do_pop)
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);
        if (do_push && !do_pop)
            count_next = count_reg + CNT_W'(1);
        else if (do_pop && !do_push)
            count_next = count_reg - CNT_W'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            mem[wr_ptr_reg] <= push_entry;
    end

endmodule

// ----- rtl/hsce_back.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hsce_back: escape sequence emitter
// Walks the queued request's sequence into an output register, one byte per cycle unless stalled.
// ----------------------------------------------------------------------------
module hsce_back (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  q_valid,
    input  hsce_pkg::hsce_entry_t q_entry,
    output logic                  q_pop,
    hsce_out_if.source            esc
);

    hsce_pkg::idx_t  idx_reg, idx_next;
    logic            out_valid_reg, out_valid_next;
    hsce_pkg::byte_t out_byte_reg;
    logic            run_last_reg;
    logic            emit;
    logic            last;

    assign emit  = q_valid && (!out_valid_reg || esc.ready);
    assign last  = (idx_reg == hsce_pkg::run_len(q_entry.cls) - hsce_pkg::IDX_W'(1));
    assign q_pop = emit && last;

    always_comb
    begin
        idx_next = idx_reg;
        if (emit)
            idx_next = last ? '0 : idx_reg + hsce_pkg::IDX_W'(1);
    end

    always_comb
    begin
        if (emit)
            out_valid_next = 1'b1;
        else if (esc.ready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            idx_reg       <= idx_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            out_byte_reg <= hsce_pkg::run_byte(q_entry.cls, q_entry.ch, idx_reg);
            run_last_reg <= last;
        end
    end

    assign esc.valid    = out_valid_reg;
    assign esc.out_byte = out_byte_reg;
    assign esc.run_last = run_last_reg;

endmodule

// ----- rtl/html_sql_char_escaper_unit.sv -----
`timescale 1ns / 1ps
// The first escaped byte of a request passes through the intake register, the queue
// and the output register before it is presented.
// Throughput: one input byte per cycle, when the output is not stalled, for bytes that
// map to a single byte; an expanding byte occupies the emitter for its whole sequence
// of 2 to 6 bytes, so the emitter's one-byte-per-cycle output sets the sustained rate.
// Reset: rst_n clears the intake stage, queue pointers and emitter state.
// ----------------------------------------------------------------------------
// html_sql_char_escaper_unit: top level of the character escaper
// Intake/classify stage, request queue and escape sequence emitter.
// ----------------------------------------------------------------------------
module html_sql_char_escaper_unit #(
    parameter int QUEUE_DEPTH = hsce_pkg::QUEUE_DEPTH
) (
    input  logic       clk,
    input  logic       rst_n,
    hsce_in_if.sink    raw,
    hsce_out_if.source esc
);

    logic                  push_valid;
    logic                  push_ready;
    hsce_pkg::hsce_entry_t push_entry;
    logic                  q_valid;
    logic                  q_pop;
    hsce_pkg::hsce_entry_t q_entry;

    hsce_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .raw        (raw),
        .push_valid (push_valid),
        .push_entry (push_entry),
        .push_ready (push_ready)
    );

    hsce_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_entry (push_entry),
        .push_ready (push_ready),
        .pop_valid  (q_valid),
        .pop_entry  (q_entry),
        .pop        (q_pop)
    );

    hsce_back u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .q_valid (q_valid),
        .q_entry (q_entry),
        .q_pop   (q_pop),
        .esc     (esc)
    );

endmodule

// ----- tb/sv/escape_run_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// escape_run_checker: scoreboard for the character escaper
// Watches both channels, builds the escaped byte run for each raw byte that
// goes in, and compares every escaped byte that comes out against it in order.
// ----------------------------------------------------------------------------
module escape_run_checker
    import hsce_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    hsce_in_if   raw,
    hsce_out_if  esc,
    output int   mismatch_count,
    output int   bytes_pending
);

    typedef struct packed {
        byte_t value;
        logic  last;
    } esc_byte_t;

    esc_byte_t escaped_q[$];
    esc_byte_t want;

    // Appends the escaped run for one raw byte; non-printable bytes add nothing.
    function automatic void push_escaped_run(input byte_t ch);
        string entity;
        byte_t run[$];
        entity = "";
        case (ch)
            CH_LT:   entity = "&lt;";
            CH_GT:   entity = "&gt;";
            CH_AMP:  entity = "&amp;";
            CH_QUOT: entity = "&quot;";
            CH_APOS: entity = "&#39;";
            CH_SEMI, CH_DASH, CH_SLASH, CH_BSLASH, CH_PCT, CH_USCORE:
            begin
                run.push_back(CH_BSLASH);
                run.push_back(ch);
            end
            default:
            begin
                if (ch >= PRINT_LO && ch <= PRINT_HI)
                    run.push_back(ch);
            end
        endcase
        for (int i = 0; i < entity.len(); i++)
            run.push_back(byte_t'(entity[i]));
        foreach (run[i])
            escaped_q.push_back(esc_byte_t'{value: run[i], last: (i == run.size() - 1)});
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            escaped_q.delete();
            mismatch_count = 0;
        end
        else
        begin
            // drain before fill: an output byte can never belong to this edge's request
            if (esc.valid && esc.ready)
            begin
                if (escaped_q.size() == 0)
                begin
                    $display("%0t: unexpected escaped byte: expected none, actual 0x%02h last=%0b",
                             $time, esc.out_byte, esc.run_last);
                    mismatch_count++;
                end
                else
                begin
                    want = escaped_q.pop_front();
                    if (esc.out_byte !== want.value)
                    begin
                        $display("%0t: out_byte mismatch: expected 0x%02h, actual 0x%02h",
                                 $time, want.value, esc.out_byte);
                        mismatch_count++;
                    end
                    if (esc.run_last !== want.last)
                    begin
                        $display("%0t: run_last mismatch: expected %0b, actual %0b",
                                 $time, want.last, esc.run_last);
                        mismatch_count++;
                    end
                end
            end
            if (raw.valid && raw.ready)
                push_escaped_run(raw.in_byte);
        end
        bytes_pending = escaped_q.size();
    end

endmodule

// ----- tb/sv/tb_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: testbench top for the character escaper
// Drives directed and random text bytes with random gaps and output stalls,
// then reports the verdict from the scoreboard's mismatch count.
// ----------------------------------------------------------------------------
module tb_top;
    import hsce_pkg::*;

    logic clk;
    logic rst_n;
    int   mismatch_count;
    int   bytes_pending;
    bit   calm;

    byte_t specials[11] = '{CH_LT, CH_GT, CH_AMP, CH_QUOT, CH_APOS, CH_SEMI,
                            CH_DASH, CH_SLASH, CH_BSLASH, CH_PCT, CH_USCORE};

    // range edges, the drop region and every escaped character
    byte_t directed[20] = '{8'h00, 8'h1F, 8'h20, 8'h7E, 8'h7F, 8'h80, 8'hFF,
                            CH_LT, CH_GT, CH_AMP, CH_QUOT, CH_APOS, CH_SEMI,
                            CH_DASH, CH_SLASH, CH_BSLASH, CH_PCT, CH_USCORE,
                            8'h41, 8'h30};

    hsce_in_if  raw_ch ();
    hsce_out_if esc_ch ();

    html_sql_char_escaper_unit dut (
        .clk   (clk),
        .rst_n (rst_n),
        .raw   (raw_ch),
        .esc   (esc_ch)
    );

    escape_run_checker run_chk (
        .clk            (clk),
        .rst_n          (rst_n),
        .raw            (raw_ch),
        .esc            (esc_ch),
        .mismatch_count (mismatch_count),
        .bytes_pending  (bytes_pending)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    initial
    begin
        #2_000_000;
        $display("FAIL html_sql_char_escaper_unit");
        $finish;
    end

    // held low through reset
    always @(posedge clk)
        esc_ch.ready <= rst_n && (calm || ($urandom_range(99) >= 26));

    task automatic send_text_byte(input byte_t b);
        raw_ch.valid   <= 1'b1;
        raw_ch.in_byte <= b;
        @(posedge clk);
        while (!raw_ch.ready)
            @(posedge clk);
        if (!calm && $urandom_range(99) < 26)
        begin
            raw_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 5)) @(posedge clk);
        end
    endtask

    // mostly escaped and printable characters, some of the full byte range
    function automatic byte_t pick_text_byte();
        int sel;
        sel = $urandom_range(99);
        if (sel < 40)
            return specials[$urandom_range(10)];
        if (sel < 80)
            return byte_t'($urandom_range(PRINT_LO, PRINT_HI));
        return byte_t'($urandom_range(255));
    endfunction

    initial
    begin
        int    sent;
        bit    paused;
        byte_t b;

        rst_n          <= 1'b0;
        raw_ch.valid   <= 1'b0;
        raw_ch.in_byte <= '0;
        calm = 1'b0;
        sent = 0;
        paused = 1'b0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed[i])
            send_text_byte(directed[i]);

        // random requests fill out the total after the directed ones
        while (sent < 380 - $size(directed))
        begin
            b = pick_text_byte();
            sent++;
            calm = (sent >= 130 && sent < 200);
            send_text_byte(b);
            if (!paused && sent >= 240)
            begin
                paused = 1'b1;
                raw_ch.valid <= 1'b0;
                @(posedge clk);
                while (bytes_pending != 0)
                    @(posedge clk);
            end
        end
        calm = 1'b0;

        raw_ch.valid <= 1'b0;
        @(posedge clk);
        while (bytes_pending != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);

        if (mismatch_count == 0)
            $display("PASS html_sql_char_escaper_unit");
        else
            $display("FAIL html_sql_char_escaper_unit");
        $finish;
    end

endmodule
